/* sv/rk4sf_pkg.sv */
// Shared types, widths and the saturation helper of the RK4 spring-friction step block.
package rk4sf_pkg;

    // Q8.24 data word and the guard width used ahead of saturation.
    localparam int DATA_W = 32;
    localparam int WIDE_W = 40;

    // Weighted sum of the four slopes (k0 + 2*k1 + 2*k2 + k3) needs 35 signed bits.
    localparam int SUM_W  = 35;

    // Rounded sum divided by six, signed.
    localparam int QUOT_W = 33;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd2;

    localparam int STEP_W = 31;
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 31'd16777;

    // A clamped value together with its overflow mark.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } sat_t;

    // Clamps a 40-bit signed value into the signed 32-bit range.
    function automatic sat_t sat40(input logic signed [WIDE_W-1:0] x);
        sat_t r;
        if (x[WIDE_W-1:DATA_W-1] == {(WIDE_W-DATA_W+1){x[DATA_W-1]}})
        begin
            r.val = x[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        else
        begin
            r.val = x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

/* sv/rk4_spring_friction_step.sv */
// Top level of the RK4 spring-friction step block: sequencer, state and result register.
//
//  Channel   Direction  Handshake            Beat contents (lowest bits first)
//  s_*       in         s_tvalid/s_tready    tdata: load_angle, load_velocity; tuser: func
//  m_*       out        m_tvalid/m_tready    tdata: angle, velocity; tuser: saturated
//  cfg_*     in         cfg_wr_en            cfg_index selects gain, bias or step size
//
// A load beat (func = 0) writes the state and moves the block to its done state, from which
// the result enters the output register. A step beat (func = 1) runs a sequence of twelve
// products issued back to back through the single shared multiplier, the finish of the last
// product, the divide-by-six pipeline and one final add. The result then enters the output
// register, and s_tready rises again as it does. If the output register is still full, the
// block holds its result until m_tready frees it. Reset clears the state, the gain and bias
// registers and all control, and loads the step size register with its reset value.
module rk4_spring_friction_step (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [rk4sf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rk4sf_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [2*rk4sf_pkg::DATA_W-1:0]         s_tdata,   // load_angle, load_velocity
    input  logic [0:0]                             s_tuser,   // func
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [2*rk4sf_pkg::DATA_W-1:0]         m_tdata,   // angle, velocity
    output logic [0:0]                             m_tuser    // saturated
);

    localparam int DW = rk4sf_pkg::DATA_W;
    localparam int WW = rk4sf_pkg::WIDE_W;
    localparam int SW = rk4sf_pkg::SUM_W;
    localparam int QW = rk4sf_pkg::QUOT_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Product kinds issued to the shared multiplier, in issue order within a stage.
    localparam logic [1:0] K_GAIN_TA = 2'd0;
    localparam logic [1:0] K_H_TV    = 2'd1;
    localparam logic [1:0] K_H_ACC   = 2'd2;

    // Stage two builds its point with the full slope; stage three builds none.
    localparam logic [1:0] STAGE_FULL = 2'd2;
    localparam logic [1:0] STAGE_END  = 2'd3;

    localparam logic [4:0] ISSUE_COUNT = 5'd12;
    localparam logic [4:0] FINAL_STEP  = 5'd16;

    logic [1:0]                    state_reg, state_next;
    logic [4:0]                    cnt_reg, cnt_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [1:0]                    stage_reg, stage_next;
    logic                          post_vld_reg, post_vld_next;
    logic [1:0]                    post_kind_reg, post_kind_next;
    logic [1:0]                    post_stage_reg, post_stage_next;

    logic signed [DW-1:0]          gain_reg, gain_next;
    logic signed [DW-1:0]          bias_reg, bias_next;
    logic [rk4sf_pkg::STEP_W-1:0]  h_reg, h_next;

    logic signed [DW-1:0]          angle_reg, angle_next;
    logic signed [DW-1:0]          velocity_reg, velocity_next;
    logic signed [DW-1:0]          ta_reg, ta_next;
    logic signed [DW-1:0]          tv_reg, tv_next;
    logic signed [DW-1:0]          acc_reg, acc_next;
    logic signed [SW-1:0]          sum_a_reg, sum_a_next;
    logic signed [SW-1:0]          sum_v_reg, sum_v_next;
    logic                          sat_reg, sat_next;

    logic                          out_vld_reg, out_vld_next;
    logic signed [DW-1:0]          out_angle_reg, out_angle_next;
    logic signed [DW-1:0]          out_vel_reg, out_vel_next;
    logic                          out_sat_reg, out_sat_next;

    logic                          in_beat;
    logic                          out_free;
    logic                          issue;
    logic signed [DW-1:0]          op_a;
    logic signed [DW-1:0]          op_b;
    rk4sf_pkg::sat_t               mul_res;
    logic signed [QW-1:0]          quot_a;
    logic signed [QW-1:0]          quot_v;

    logic signed [WW-1:0]          r40;
    logic signed [DW:0]            r_inc;
    logic signed [WW-1:0]          half40;
    logic signed [WW-1:0]          step_inc;
    logic signed [SW-1:0]          k_weighted;
    rk4sf_pkg::sat_t               acc_sat;
    rk4sf_pkg::sat_t               ang_pt;
    rk4sf_pkg::sat_t               vel_pt;
    rk4sf_pkg::sat_t               fin_a;
    rk4sf_pkg::sat_t               fin_v;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign issue    = (state_reg == ST_RUN) && (cnt_reg < ISSUE_COUNT);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (kind_reg)
            K_GAIN_TA:
            begin
                op_a = gain_reg;
                op_b = ta_reg;
            end
            K_H_TV:
            begin
                op_a = {1'b0, h_reg};
                op_b = tv_reg;
            end
            K_H_ACC:
            begin
                op_a = {1'b0, h_reg};
                op_b = acc_reg;
            end
            default:
            begin
                op_a = gain_reg;
                op_b = ta_reg;
            end
        endcase
    end

    rk4sf_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .res  (mul_res)
    );

    rk4sf_div6 u_div_a (
        .clk  (clk),
        .sum  (sum_a_reg),
        .quot (quot_a)
    );

    rk4sf_div6 u_div_v (
        .clk  (clk),
        .sum  (sum_v_reg),
        .quot (quot_v)
    );

    // Post-processing of the product that left the multiplier this cycle.
    // The acceleration is bias minus gain times the stage angle; a slope k
    // moves the stage point by half of k (k + 1 shifted right once, matching a
    // rounded product with one half) in stages zero and one, and by all of k in stage two.
    assign r40        = {{(WW-DW){mul_res.val[DW-1]}}, mul_res.val};
    assign r_inc      = {mul_res.val[DW-1], mul_res.val} + (DW+1)'(1);
    assign half40     = {{(WW-DW){r_inc[DW]}}, r_inc[DW:1]};
    assign step_inc   = (post_stage_reg == STAGE_FULL) ? r40 : half40;
    assign k_weighted = ((post_stage_reg == 2'd1) || (post_stage_reg == STAGE_FULL))
                      ? {{(SW-DW-1){mul_res.val[DW-1]}}, mul_res.val, 1'b0}
                      : {{(SW-DW){mul_res.val[DW-1]}}, mul_res.val};
    assign acc_sat    = rk4sf_pkg::sat40({{(WW-DW){bias_reg[DW-1]}}, bias_reg} - r40);
    assign ang_pt     = rk4sf_pkg::sat40({{(WW-DW){angle_reg[DW-1]}}, angle_reg} + step_inc);
    assign vel_pt     = rk4sf_pkg::sat40({{(WW-DW){velocity_reg[DW-1]}}, velocity_reg}
                                         + step_inc);

    // Final update: state plus the rounded sixth of the weighted slope sum.
    assign fin_a = rk4sf_pkg::sat40({{(WW-DW){angle_reg[DW-1]}}, angle_reg}
                                    + {{(WW-QW){quot_a[QW-1]}}, quot_a});
    assign fin_v = rk4sf_pkg::sat40({{(WW-DW){velocity_reg[DW-1]}}, velocity_reg}
                                    + {{(WW-QW){quot_v[QW-1]}}, quot_v});

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        kind_next       = kind_reg;
        stage_next      = stage_reg;
        post_vld_next   = issue;
        post_kind_next  = kind_reg;
        post_stage_next = stage_reg;
        gain_next       = gain_reg;
        bias_next       = bias_reg;
        h_next          = h_reg;
        angle_next      = angle_reg;
        velocity_next   = velocity_reg;
        ta_next         = ta_reg;
        tv_next         = tv_reg;
        acc_next        = acc_reg;
        sum_a_next      = sum_a_reg;
        sum_v_next      = sum_v_reg;
        sat_next        = sat_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_angle_next  = out_angle_reg;
        out_vel_next    = out_vel_reg;
        out_sat_next    = out_sat_reg;

        // The user must send configuration writes only while the block is idle; the block does not enforce it.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                rk4sf_pkg::REG_ACCEL_GAIN: gain_next = cfg_data;
                rk4sf_pkg::REG_ACCEL_BIAS: bias_next = cfg_data;
                rk4sf_pkg::REG_STEP_SIZE:  h_next    = cfg_data[rk4sf_pkg::STEP_W-1:0];
                default:                   gain_next = gain_reg;
            endcase
        end

        // Advance the product kind and stage after each issue.
        if (issue)
        begin
            case (kind_reg)
                K_GAIN_TA: kind_next = K_H_TV;
                K_H_TV:    kind_next = K_H_ACC;
                K_H_ACC:
                begin
                    kind_next  = K_GAIN_TA;
                    stage_next = stage_reg + 2'd1;
                end
                default:   kind_next = K_GAIN_TA;
            endcase
        end

        if (post_vld_reg)
        begin
            sat_next = sat_next | mul_res.ovf;
            case (post_kind_reg)
                K_GAIN_TA:
                begin
                    acc_next = acc_sat.val;
                    sat_next = sat_next | acc_sat.ovf;
                end
                K_H_TV:
                begin
                    sum_a_next = sum_a_reg + k_weighted;
                    if (post_stage_reg != STAGE_END)
                    begin
                        ta_next  = ang_pt.val;
                        sat_next = sat_next | ang_pt.ovf;
                    end
                end
                K_H_ACC:
                begin
                    sum_v_next = sum_v_reg + k_weighted;
                    if (post_stage_reg != STAGE_END)
                    begin
                        tv_next  = vel_pt.val;
                        sat_next = sat_next | vel_pt.ovf;
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    sat_next = 1'b0;
                    if (s_tuser[0] == 1'b0)
                    begin
                        angle_next    = s_tdata[DW-1:0];
                        velocity_next = s_tdata[2*DW-1:DW];
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        ta_next    = angle_reg;
                        tv_next    = velocity_reg;
                        sum_a_next = '0;
                        sum_v_next = '0;
                        cnt_next   = '0;
                        kind_next  = K_GAIN_TA;
                        stage_next = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == FINAL_STEP)
                begin
                    angle_next    = fin_a.val;
                    velocity_next = fin_v.val;
                    sat_next      = sat_next | fin_a.ovf | fin_v.ovf;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_angle_next = angle_reg;
                    out_vel_next   = velocity_reg;
                    out_sat_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            kind_reg       <= K_GAIN_TA;
            stage_reg      <= '0;
            post_vld_reg   <= 1'b0;
            post_kind_reg  <= K_GAIN_TA;
            post_stage_reg <= '0;
            gain_reg       <= '0;
            bias_reg       <= '0;
            h_reg          <= rk4sf_pkg::STEP_SIZE_RESET;
            angle_reg      <= '0;
            velocity_reg   <= '0;
            sat_reg        <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            kind_reg       <= kind_next;
            stage_reg      <= stage_next;
            post_vld_reg   <= post_vld_next;
            post_kind_reg  <= post_kind_next;
            post_stage_reg <= post_stage_next;
            gain_reg       <= gain_next;
            bias_reg       <= bias_next;
            h_reg          <= h_next;
            angle_reg      <= angle_next;
            velocity_reg   <= velocity_next;
            sat_reg        <= sat_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Working values and the result payload need no reset.
    always_ff @(posedge clk)
    begin
        ta_reg        <= ta_next;
        tv_reg        <= tv_next;
        acc_reg       <= acc_next;
        sum_a_reg     <= sum_a_next;
        sum_v_reg     <= sum_v_next;
        out_angle_reg <= out_angle_next;
        out_vel_reg   <= out_vel_next;
        out_sat_reg   <= out_sat_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_vel_reg, out_angle_reg};
    assign m_tuser  = out_sat_reg;

    // An accepted beat always takes the block out of idle.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input accepted while previous item still in progress");

    // A product finishes only while the step sequence is running.
    a_post_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        post_vld_reg |-> (state_reg == ST_RUN))
        else $error("multiplier result arrived outside a step sequence");

    // The step sequence leaves the run state only at its final count.
    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (cnt_reg != FINAL_STEP)) |=> (state_reg == ST_RUN))
        else $error("step sequence ended early");

    // The count never runs past the final step.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= FINAL_STEP))
        else $error("step counter overran");

endmodule

/* sv/rk4sf_mul.sv */
// Shared Q8.24 multiplier: registered full product, then round-to-nearest and clamp.
module rk4sf_mul (
    input  logic                                clk,
    input  logic signed [rk4sf_pkg::DATA_W-1:0] op_a,
    input  logic signed [rk4sf_pkg::DATA_W-1:0] op_b,
    output rk4sf_pkg::sat_t                     res
);

    localparam int PROD_W = 2 * rk4sf_pkg::DATA_W;
    localparam int FRAC_W = 24;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rounded;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Adding one half and shifting arithmetically rounds ties toward plus infinity.
    assign rounded = prod_reg + (PROD_W'(1) <<< (FRAC_W - 1));
    assign res     = rk4sf_pkg::sat40(rounded[PROD_W-1:FRAC_W]);

endmodule

/* sv/rk4sf_div6.sv */
// Three-stage pipeline that divides the weighted slope sum by six, rounding ties away from zero.
module rk4sf_div6 (
    input  logic                                clk,
    input  logic signed [rk4sf_pkg::SUM_W-1:0]  sum,
    output logic signed [rk4sf_pkg::QUOT_W-1:0] quot
);

    localparam int MAG_W   = 34;
    localparam int LO_W    = 18;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int X_W     = 21;
    localparam int Q_W     = 19;
    localparam int QH_W    = 14;
    localparam int R_W     = 3;
    localparam int RCP_W   = 22;
    localparam int PRD_W   = X_W + RCP_W;
    localparam int RCP_SH  = 24;
    localparam logic [RCP_W-1:0] RECIP_6 = 22'd2796203;

    // Exact floor(x / 6) for every x below 2^21, the full input range, by a reciprocal multiply.
    function automatic logic [Q_W-1:0] div6(input logic [X_W-1:0] x);
        logic [PRD_W-1:0] p;
        p = PRD_W'(x) * PRD_W'(RECIP_6);
        return p[RCP_SH+Q_W-1:RCP_SH];
    endfunction

    logic [rk4sf_pkg::SUM_W-1:0] mag;
    logic [MAG_W-1:0]            m_reg;
    logic                        neg1_reg;
    logic [X_W-1:0]              x_hi;
    logic [Q_W-1:0]              q_hi;
    logic [X_W-1:0]              rem_hi;
    logic [QH_W-1:0]             qh_reg;
    logic [R_W-1:0]              rh_reg;
    logic [LO_W-1:0]             ml_reg;
    logic                        neg2_reg;
    logic [Q_W-1:0]              q_lo;
    logic [rk4sf_pkg::QUOT_W-1:0] q_mag;

    assign mag    = sum[rk4sf_pkg::SUM_W-1] ? -sum : sum;
    assign x_hi   = {{(X_W-HI_W){1'b0}}, m_reg[MAG_W-1:LO_W]};
    assign q_hi   = div6(x_hi);
    assign rem_hi = x_hi - X_W'(q_hi * X_W'(6));
    assign q_lo   = div6({rh_reg, ml_reg});
    assign q_mag  = {1'b0, qh_reg, q_lo[LO_W-1:0]};

    always_ff @(posedge clk)
    begin
        m_reg    <= mag[MAG_W-1:0] + MAG_W'(3);
        neg1_reg <= sum[rk4sf_pkg::SUM_W-1];
        qh_reg   <= q_hi[QH_W-1:0];
        rh_reg   <= rem_hi[R_W-1:0];
        ml_reg   <= m_reg[LO_W-1:0];
        neg2_reg <= neg1_reg;
        quot     <= neg2_reg ? -q_mag : q_mag;
    end

endmodule
